// ----- rtl/core/utf8_lenient_decoder_unit_defines.svh -----
// Assertion macros shared by the lenient UTF-8 decoder RTL.
// Expects a clock clk and an active-low reset rst_n in the using module.
`ifndef UTF8_LENIENT_DECODER_UNIT_DEFINES_SVH
`define UTF8_LENIENT_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define U8D_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define U8D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/utf8d_pkg.sv -----
// Shared types and constants for the lenient UTF-8 decoder.
// No dependencies; imported by utf8d_decode and utf8_lenient_decoder_unit.
package utf8d_pkg;

    localparam int CP_W        = 21;
    localparam int MAX_RESULTS = 4;
    localparam int HOLD_DEPTH  = 3;

    typedef logic [7:0]      byte_t;
    typedef logic [CP_W-1:0] cp_t;
    typedef logic [2:0]      len_t;   // sequence length or result count, 0 to 4
    typedef logic [1:0]      cnt_t;   // number of held bytes, 0 to 3

    typedef logic [MAX_RESULTS-1:0][CP_W-1:0] cp_set_t;
    typedef logic [HOLD_DEPTH-1:0][7:0]       held_set_t;

    // Lead byte classes
    localparam byte_t LEAD2_MASK = 8'hE0;
    localparam byte_t LEAD2_CODE = 8'hC0;
    localparam byte_t LEAD3_MASK = 8'hF0;
    localparam byte_t LEAD3_CODE = 8'hE0;
    localparam byte_t LEAD4_MASK = 8'hF8;
    localparam byte_t LEAD4_CODE = 8'hF0;

    localparam len_t LEN1 = 3'd1;
    localparam len_t LEN2 = 3'd2;
    localparam len_t LEN3 = 3'd3;
    localparam len_t LEN4 = 3'd4;

    localparam cp_t REPLACEMENT_CP = 21'h00FFFD;

    // Outcome of decoding one word against the held bytes
    typedef struct packed {
        logic    hold;    // sequence still open: keep the byte, emit nothing
        len_t    count;   // number of code points produced
        cp_set_t cp;      // code points, entry 0 first
    } dec_res_t;

endpackage

// ----- rtl/core/utf8d_decode.sv -----
// Combinational decode of the held bytes plus one new byte into code points.
// Depends on utf8d_pkg.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  held_set_t held_bytes,
    input  cnt_t      held_count,
    input  byte_t     in_byte,
    input  logic      end_of_stream,
    output dec_res_t  res
);

    // Sequence length implied by a lead byte
    function automatic len_t lead_len(input byte_t b);
        len_t l;
        l = LEN1;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            l = LEN2;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            l = LEN3;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            l = LEN4;
        end
        return l;
    endfunction

    byte_t win [MAX_RESULTS];
    len_t  n;

    // Assemble the byte window: held bytes first, new byte at held_count
    always_comb
    begin
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            win[i] = (cnt_t'(i) == held_count) ? in_byte : held_bytes[i];
        end
        win[HOLD_DEPTH] = in_byte;
        n = len_t'(held_count) + LEN1;
    end

    // Walk the window, one code point per step
    always_comb
    begin
        len_t  pos;
        len_t  avail;
        len_t  len;
        len_t  adv;
        byte_t b0;
        byte_t b1;
        byte_t b2;
        byte_t b3;
        cp_t   cp;

        res.hold  = !end_of_stream && (n < lead_len(win[0]));
        res.count = '0;
        res.cp    = '0;
        pos       = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            b0    = win[pos[1:0]];
            b1    = win[pos[1:0] + 2'd1];
            b2    = win[pos[1:0] + 2'd2];
            b3    = win[pos[1:0] + 2'd3];
            len   = lead_len(b0);
            avail = n - pos;
            adv   = LEN1;
            if (!b0[7])
            begin
                cp = cp_t'(b0);
            end
            else if (len == LEN1 || avail < len)
            begin
                cp = REPLACEMENT_CP;
            end
            else
            begin
                adv = len;
                unique case (len)
                    LEN2:    cp = {10'd0, b0[4:0], b1[5:0]};
                    LEN3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                    default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                endcase
            end
            if (!res.hold && pos < n)
            begin
                res.cp[k] = cp;
                res.count = len_t'(k + 1);
                pos       = pos + adv;
            end
        end
    end

endmodule

// ----- rtl/core/utf8_lenient_decoder_unit.sv -----
// Lenient UTF-8 decoder top level: input word register, decode, result buffer.
// Depends on utf8d_pkg, utf8d_decode and utf8_lenient_decoder_unit_defines.svh.
//
//  channel | side   | tdata                   | tlast
//  --------+--------+-------------------------+---------------
//  s_*     | in     | [7:0] in_byte           | end_of_stream
//  m_*     | out    | [20:0] code_point, pad  | run_last
//
// One input word per cycle while the result buffer can take each decoded set;
// the decode runs between the input register and the result buffer, so a
// code point passes the input register and then the result buffer.
// An end-of-stream word can produce up to three code points; the result buffer
// drains one per cycle while m_tready is high, holding that set until all are taken.
// Reset clears the held-byte count and both valid flags; held bytes are
// only read once written. Output stalls back up through the input register.
`include "utf8_lenient_decoder_unit_defines.svh"

module utf8_lenient_decoder_unit
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tlast
);

    logic      in_valid_reg;
    byte_t     in_byte_reg;
    logic      in_eos_reg;
    held_set_t held_bytes_reg;
    cnt_t      held_count_reg;
    cnt_t      held_count_next;
    len_t      out_cnt_reg;
    len_t      out_cnt_next;
    cp_set_t   cp_reg;
    dec_res_t  dec;
    logic      out_can_load;
    logic      consume;

    // Decode the registered word against the held bytes
    utf8d_decode u_decode (
        .held_bytes    (held_bytes_reg),
        .held_count    (held_count_reg),
        .in_byte       (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .res           (dec)
    );

    // Handshake between stages
    assign out_can_load = (out_cnt_reg == '0) || (out_cnt_reg == LEN1 && m_tready);
    assign consume      = in_valid_reg && out_can_load;
    assign s_tready     = !in_valid_reg || consume;

    // Input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    // Held sequence: keep the byte while open, clear once decoded
    always_comb
    begin
        held_count_next = held_count_reg;
        if (consume)
        begin
            held_count_next = dec.hold ? held_count_reg + 2'd1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
        end
        else
        begin
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && dec.hold)
        begin
            held_bytes_reg[held_count_reg] <= in_byte_reg;
        end
    end

    // Result buffer: load a set, then advance one code point per handshake
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (consume)
        begin
            out_cnt_next = dec.hold ? len_t'(0) : dec.count;
        end
        else if (m_tvalid && m_tready)
        begin
            out_cnt_next = out_cnt_reg - LEN1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            cp_reg <= dec.cp;
        end
        else if (m_tvalid && m_tready)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                cp_reg[i] <= cp_reg[i+1];
            end
        end
    end

    // Drive the output word from the head of the buffer
    assign m_tvalid = (out_cnt_reg != '0);
    assign m_tdata  = {3'd0, cp_reg[0]};
    assign m_tlast  = (out_cnt_reg == LEN1);

    // Checks on the decode/buffer hand-off
    `U8D_ASSERT_SAME(a_hold_bounded,
        in_valid_reg && !in_eos_reg && held_count_reg == 2'd3, !dec.hold,
        "open sequence grew past three held bytes")
    `U8D_ASSERT_NEXT(a_hold_no_output, consume && dec.hold,
        out_cnt_reg == '0 && held_count_reg != '0,
        "held word produced output or lost its byte")
    `U8D_ASSERT_NEXT(a_decode_output, consume && !dec.hold,
        out_cnt_reg != '0 && held_count_reg == '0,
        "decoded word produced no code point or kept held bytes")
    `U8D_ASSERT_NEXT(a_eos_clears, consume && in_eos_reg, held_count_reg == '0,
        "end of stream left held bytes")

endmodule
